// ----- hdl/fhle_pkg.sv -----
package fhle_pkg;

  // frame and field geometry
  localparam int HEADER_BYTES = 10;
  localparam int MAX_FRAME    = 63;
  localparam int MAX_SEND     = MAX_FRAME - HEADER_BYTES;
  localparam int MOVE_CHECK   = 20;

  localparam int LEN_W  = 6;
  localparam int TYPE_W = 4;
  localparam int ACT_W  = 4;
  localparam int CFG_AW = 3;
  localparam int CID_W  = 6;
  localparam int TICK_W = 8;

  localparam int DIR_BIT = 5;
  localparam logic [TYPE_W-1:0] BUSY_CODE = 4'h8;
  localparam logic [TICK_W-1:0] RETRY_GAP = 8'd2;
  localparam logic [TICK_W-1:0] FIRST_GAP = 8'd3;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // input opcodes
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_SEND  = 2'd2;

  // frame types in header bits 7:6
  localparam logic [1:0] PT_DATA   = 2'd0;
  localparam logic [1:0] PT_COMMIT = 2'd1;
  localparam logic [1:0] PT_ACK    = 2'd2;
  localparam logic [1:0] PT_CACK   = 2'd3;

  // result actions
  localparam logic [ACT_W-1:0] ACT_DATA        = 4'd0;
  localparam logic [ACT_W-1:0] ACT_ACK         = 4'd1;
  localparam logic [ACT_W-1:0] ACT_COMMIT      = 4'd2;
  localparam logic [ACT_W-1:0] ACT_COMMIT_ACK  = 4'd3;
  localparam logic [ACT_W-1:0] ACT_BROADCAST   = 4'd4;
  localparam logic [ACT_W-1:0] ACT_DELIVER     = 4'd5;
  localparam logic [ACT_W-1:0] ACT_DELIVER_BUF = 4'd6;
  localparam logic [ACT_W-1:0] ACT_DONE        = 4'd7;
  localparam logic [ACT_W-1:0] ACT_BUSY        = 4'd8;
  localparam logic [ACT_W-1:0] ACT_ERROR       = 4'd9;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_MAX_RETRIES = 3'd0;
  localparam logic [CFG_AW-1:0] REG_NETWORK_ID  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_DEVICE_ID   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_PARENT      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CODE_HS     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_CODE_BC     = 3'd5;
  localparam logic [CFG_AW-1:0] REG_CODE_UA     = 3'd6;

  typedef struct packed {
    logic [7:0]        max_retries;
    logic [31:0]       network_id;
    logic [31:0]       device_id;
    logic [CID_W-1:0]  parent;
    logic [TYPE_W-1:0] code_hs;
    logic [TYPE_W-1:0] code_bc;
    logic [TYPE_W-1:0] code_ua;
  } cfg_t;

  // classified transaction kinds
  typedef enum logic [3:0] {
    K_TICK,
    K_ACK,
    K_ACK_BUSY,
    K_CACK,
    K_DELIVER,
    K_DATA_HS,
    K_COMMIT,
    K_SEND_HS,
    K_SEND_UA,
    K_SEND_BC
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [TYPE_W-1:0] typ;
    logic [LEN_W-1:0]  len;
  } item_t;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [TYPE_W-1:0] typ;
    logic [LEN_W-1:0]  len;
    logic              last;
  } result_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  typedef struct packed {
    logic pend;
  } back_stat_t;

endpackage

// ----- hdl/four_way_handshake_link_engine.sv -----
// Path: a transaction is held in the classify register, then in a queue entry, and is then
// executed into the output register.
// Throughput: one transaction per cycle unless a stall holds it; a commit that delivers a
// buffered frame gives two results, which leave the single output register one after the other.
// Reset (rst_n low at a clock edge) empties both records, the queue and the output,
// clears the tick counter and loads the configuration registers with their defaults.
module four_way_handshake_link_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_opcode,
  input  logic [7:0]                       in_frame_header,
  input  logic [31:0]                      in_frame_network,
  input  logic [31:0]                      in_frame_destination,
  input  logic [7:0]                       in_frame_source,
  input  logic [fhle_pkg::LEN_W-1:0]       in_frame_length,
  input  logic                             in_move_response,
  input  logic [fhle_pkg::TYPE_W-1:0]      in_send_type,
  input  logic [fhle_pkg::LEN_W-1:0]       in_send_length,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fhle_pkg::ACT_W-1:0]       out_action,
  output logic [fhle_pkg::TYPE_W-1:0]      out_action_type,
  output logic [fhle_pkg::LEN_W-1:0]       out_action_length,
  output logic                             out_last_result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fhle_pkg::CFG_AW-1:0]      cfg_index,
  input  logic [31:0]                      cfg_data
);

  fhle_pkg::cfg_t       cfg_r;
  fhle_pkg::q_stat_t    q_stat;
  fhle_pkg::item_t      push_item;
  fhle_pkg::item_t      pop_item;
  fhle_pkg::result_t    out_res;
  fhle_pkg::back_stat_t back_stat;
  logic                 push;
  logic                 pop;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_retries <= 8'd3;
      cfg_r.network_id  <= '0;
      cfg_r.device_id   <= '0;
      cfg_r.parent      <= '0;
      cfg_r.code_hs     <= 4'd0;
      cfg_r.code_bc     <= 4'd1;
      cfg_r.code_ua     <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fhle_pkg::REG_MAX_RETRIES: cfg_r.max_retries <= cfg_data[7:0];
        fhle_pkg::REG_NETWORK_ID:  cfg_r.network_id  <= cfg_data;
        fhle_pkg::REG_DEVICE_ID:   cfg_r.device_id   <= cfg_data;
        fhle_pkg::REG_PARENT:      cfg_r.parent      <= cfg_data[fhle_pkg::CID_W-1:0];
        fhle_pkg::REG_CODE_HS:     cfg_r.code_hs     <= cfg_data[fhle_pkg::TYPE_W-1:0];
        fhle_pkg::REG_CODE_BC:     cfg_r.code_bc     <= cfg_data[fhle_pkg::TYPE_W-1:0];
        fhle_pkg::REG_CODE_UA:     cfg_r.code_ua     <= cfg_data[fhle_pkg::TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  fhle_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_frame_header      (in_frame_header),
    .in_frame_network     (in_frame_network),
    .in_frame_destination (in_frame_destination),
    .in_frame_source      (in_frame_source),
    .in_frame_length      (in_frame_length),
    .in_move_response     (in_move_response),
    .in_send_type         (in_send_type),
    .in_send_length       (in_send_length),
    .q_stat               (q_stat),
    .push                 (push),
    .push_item            (push_item)
  );

  fhle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  fhle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .q_item    (pop_item),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .stat      (back_stat)
  );

  assign out_action        = out_res.act;
  assign out_action_type   = out_res.typ;
  assign out_action_length = out_res.len;
  assign out_last_result   = out_res.last;

`ifndef SYNTH
  // a held second result always sits behind a valid first one
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.pend |-> out_valid)
    else $error("second result held with output register empty");

  // a first result that leaves is followed at once by the final one
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result && !out_stall |=> out_valid && out_last_result)
    else $error("second result of a transaction missing");

  // the queue is never full and empty at once
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> q_stat.nonempty)
    else $error("queue status inconsistent");

  // the back end never takes work while a second result is still held
  a_no_pop_while_pend: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.pend |-> !pop)
    else $error("transaction taken while a result is held");
`endif

endmodule

// ----- hdl/fhle_front.sv -----
module fhle_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fhle_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_opcode,
  input  logic [7:0]                       in_frame_header,
  input  logic [31:0]                      in_frame_network,
  input  logic [31:0]                      in_frame_destination,
  input  logic [7:0]                       in_frame_source,
  input  logic [fhle_pkg::LEN_W-1:0]       in_frame_length,
  input  logic                             in_move_response,
  input  logic [fhle_pkg::TYPE_W-1:0]      in_send_type,
  input  logic [fhle_pkg::LEN_W-1:0]       in_send_length,
  input  fhle_pkg::q_stat_t                q_stat,
  output logic                             push,
  output fhle_pkg::item_t                  push_item
);

  logic                          f_valid_r;
  fhle_pkg::item_t               f_item_r;
  fhle_pkg::item_t               item_nxt;
  logic                          keep;
  logic                          accept;
  logic                          load;
  logic                          frame_ok;
  logic [1:0]                    ptype;
  logic [fhle_pkg::TYPE_W-1:0]   tt;
  logic [fhle_pkg::LEN_W-1:0]    sl;

  assign ptype = in_frame_header[7:6];
  assign tt    = in_frame_header[fhle_pkg::TYPE_W-1:0];

  // address filter: length, network, then direction, device and parent
  always_comb begin
    frame_ok = (in_frame_length >= fhle_pkg::LEN_W'(fhle_pkg::HEADER_BYTES)) &&
               (in_frame_network == cfg.network_id);
    if (tt != cfg.code_bc) begin
      if (!in_frame_header[fhle_pkg::DIR_BIT]) frame_ok = 1'b0;
      if (in_frame_destination != cfg.device_id) frame_ok = 1'b0;
      if ((in_frame_source[fhle_pkg::CID_W-1:0] != cfg.parent) &&
          (in_frame_length > fhle_pkg::LEN_W'(fhle_pkg::MOVE_CHECK)) &&
          !in_move_response) frame_ok = 1'b0;
    end
  end

  // clamp send length to the payload room of one frame
  assign sl = (in_send_length > fhle_pkg::LEN_W'(fhle_pkg::MAX_SEND)) ?
              fhle_pkg::LEN_W'(fhle_pkg::MAX_SEND) : in_send_length;

  // classify the transaction; drop what can never give a result
  always_comb begin
    keep          = 1'b0;
    item_nxt.kind = fhle_pkg::K_TICK;
    item_nxt.typ  = tt;
    item_nxt.len  = '0;
    unique case (in_opcode)
      fhle_pkg::OP_FRAME: begin
        if (frame_ok) begin
          unique case (ptype)
            fhle_pkg::PT_ACK: begin
              keep          = 1'b1;
              item_nxt.kind = (tt == fhle_pkg::BUSY_CODE) ? fhle_pkg::K_ACK_BUSY
                                                          : fhle_pkg::K_ACK;
            end
            fhle_pkg::PT_CACK: begin
              keep          = 1'b1;
              item_nxt.kind = fhle_pkg::K_CACK;
            end
            fhle_pkg::PT_DATA: begin
              if (tt == cfg.code_ua || tt == cfg.code_bc) begin
                keep          = 1'b1;
                item_nxt.kind = fhle_pkg::K_DELIVER;
                item_nxt.len  = in_frame_length - fhle_pkg::LEN_W'(fhle_pkg::HEADER_BYTES);
              end else if (tt == cfg.code_hs) begin
                keep          = 1'b1;
                item_nxt.kind = fhle_pkg::K_DATA_HS;
                item_nxt.len  = (in_frame_length > fhle_pkg::LEN_W'(fhle_pkg::MAX_FRAME)) ?
                                fhle_pkg::LEN_W'(fhle_pkg::MAX_FRAME) : in_frame_length;
              end
            end
            fhle_pkg::PT_COMMIT: begin
              keep          = 1'b1;
              item_nxt.kind = fhle_pkg::K_COMMIT;
            end
            default: keep = 1'b0;
          endcase
        end
      end
      fhle_pkg::OP_TICK: begin
        keep          = 1'b1;
        item_nxt.kind = fhle_pkg::K_TICK;
      end
      fhle_pkg::OP_SEND: begin
        item_nxt.typ = in_send_type;
        item_nxt.len = sl;
        if (in_send_type == cfg.code_hs) begin
          keep          = 1'b1;
          item_nxt.kind = fhle_pkg::K_SEND_HS;
        end else if (in_send_type == cfg.code_ua) begin
          keep          = 1'b1;
          item_nxt.kind = fhle_pkg::K_SEND_UA;
        end else if (in_send_type == cfg.code_bc) begin
          keep          = 1'b1;
          item_nxt.kind = fhle_pkg::K_SEND_BC;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  // hold the classified transaction until the queue has room
  assign push     = f_valid_r && !q_stat.full;
  assign load     = !f_valid_r || !q_stat.full;
  assign in_stall = !load;
  assign accept   = in_valid && load;
  assign push_item = f_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (load) begin
      f_valid_r <= accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (load && accept) begin
      f_item_r <= item_nxt;
    end
  end

endmodule

// ----- hdl/fhle_queue.sv -----
module fhle_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fhle_pkg::item_t   push_item,
  input  logic              pop,
  output fhle_pkg::item_t   pop_item,
  output fhle_pkg::q_stat_t q_stat
);

  fhle_pkg::item_t              mem [fhle_pkg::QDEPTH];
  logic [fhle_pkg::QAW-1:0]     wr_ptr_r;
  logic [fhle_pkg::QAW-1:0]     rd_ptr_r;
  logic [fhle_pkg::QAW:0]       cnt_r;
  logic                         do_push;
  logic                         do_pop;

  assign q_stat.full     = (cnt_r == (fhle_pkg::QAW+1)'(fhle_pkg::QDEPTH));
  assign q_stat.nonempty = (cnt_r != '0);
  assign do_push         = push && !q_stat.full;
  assign do_pop          = pop && q_stat.nonempty;
  assign pop_item        = mem[rd_ptr_r];

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- hdl/fhle_back.sv -----
module fhle_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fhle_pkg::cfg_t       cfg,
  input  fhle_pkg::q_stat_t    q_stat,
  input  fhle_pkg::item_t      q_item,
  output logic                 pop,
  input  logic                 out_stall,
  output logic                 out_valid,
  output fhle_pkg::result_t    out_res,
  output fhle_pkg::back_stat_t stat
);

  // link records
  logic [fhle_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic                        tx_full_r, tx_full_nxt;
  logic                        tx_comm_r, tx_comm_nxt;
  logic [fhle_pkg::LEN_W-1:0]  tx_len_r, tx_len_nxt;
  logic [fhle_pkg::TYPE_W-1:0] tx_kind_r, tx_kind_nxt;
  logic [fhle_pkg::TICK_W-1:0] tx_dl_r, tx_dl_nxt;
  logic [7:0]                  tx_retry_r, tx_retry_nxt;
  logic                        rx_full_r, rx_full_nxt;
  logic [fhle_pkg::LEN_W-1:0]  rx_len_r, rx_len_nxt;
  logic [fhle_pkg::TYPE_W-1:0] rx_kind_r, rx_kind_nxt;

  // output register and second-result holding stage
  logic                        out_valid_r;
  fhle_pkg::result_t           out_r;
  logic                        pend_r;
  fhle_pkg::result_t           pend_res_r;

  fhle_pkg::result_t           r0;
  fhle_pkg::result_t           r1;
  logic [1:0]                  n_res;
  logic                        out_free;
  logic                        take;
  logic [fhle_pkg::TICK_W-1:0] tick_inc;

  assign out_free  = !out_valid_r || !out_stall;
  assign take      = q_stat.nonempty && !pend_r && out_free;
  assign pop       = take;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign stat.pend = pend_r;
  assign tick_inc  = tick_r + 1'b1;

  // execute one transaction against the records
  always_comb begin
    tick_nxt     = tick_r;
    tx_full_nxt  = tx_full_r;
    tx_comm_nxt  = tx_comm_r;
    tx_len_nxt   = tx_len_r;
    tx_kind_nxt  = tx_kind_r;
    tx_dl_nxt    = tx_dl_r;
    tx_retry_nxt = tx_retry_r;
    rx_full_nxt  = rx_full_r;
    rx_len_nxt   = rx_len_r;
    rx_kind_nxt  = rx_kind_r;
    n_res        = 2'd0;
    r0           = '0;
    r1           = '0;
    unique case (q_item.kind)
      fhle_pkg::K_TICK: begin
        tick_nxt = tick_inc;
        if (tx_full_r && tx_dl_r == tick_inc) begin
          n_res = 2'd1;
          if (tx_retry_r == '0) begin
            tx_retry_nxt = '1;
            tx_full_nxt  = 1'b0;
            r0.act = fhle_pkg::ACT_ERROR;
            r0.typ = tx_kind_r;
          end else begin
            tx_retry_nxt = tx_retry_r - 1'b1;
            tx_dl_nxt    = tick_inc + fhle_pkg::RETRY_GAP;
            if (tx_comm_r) begin
              r0.act = fhle_pkg::ACT_COMMIT;
              r0.typ = cfg.code_hs;
            end else begin
              r0.act = fhle_pkg::ACT_DATA;
              r0.typ = tx_kind_r;
              r0.len = tx_len_r;
            end
          end
        end
      end
      fhle_pkg::K_ACK: begin
        if (tx_full_r) begin
          n_res        = 2'd1;
          tx_retry_nxt = cfg.max_retries;
          tx_comm_nxt  = 1'b1;
          tx_dl_nxt    = tick_r + fhle_pkg::RETRY_GAP;
          r0.act       = fhle_pkg::ACT_COMMIT;
          r0.typ       = cfg.code_hs;
        end
      end
      fhle_pkg::K_ACK_BUSY: begin
        if (tx_full_r) begin
          n_res        = 2'd1;
          tx_retry_nxt = cfg.max_retries;
          tx_dl_nxt    = tick_r + fhle_pkg::FIRST_GAP;
          r0.act       = fhle_pkg::ACT_BUSY;
          r0.typ       = fhle_pkg::BUSY_CODE;
        end
      end
      fhle_pkg::K_CACK: begin
        n_res       = 2'd1;
        tx_full_nxt = 1'b0;
        r0.act      = fhle_pkg::ACT_DONE;
        r0.typ      = tx_kind_r;
      end
      fhle_pkg::K_DELIVER: begin
        n_res  = 2'd1;
        r0.act = fhle_pkg::ACT_DELIVER;
        r0.typ = q_item.typ;
        r0.len = q_item.len;
      end
      fhle_pkg::K_DATA_HS: begin
        n_res  = 2'd1;
        r0.act = fhle_pkg::ACT_ACK;
        r0.typ = rx_kind_r;
        if (!rx_full_r) begin
          rx_full_nxt = 1'b1;
          rx_len_nxt  = q_item.len;
          rx_kind_nxt = q_item.typ;
          r0.typ      = q_item.typ;
        end
      end
      fhle_pkg::K_COMMIT: begin
        if (rx_full_r) begin
          n_res       = 2'd2;
          rx_full_nxt = 1'b0;
          r0.act      = fhle_pkg::ACT_DELIVER_BUF;
          r0.typ      = rx_kind_r;
          r0.len      = (rx_len_r >= fhle_pkg::LEN_W'(fhle_pkg::HEADER_BYTES)) ?
                        rx_len_r - fhle_pkg::LEN_W'(fhle_pkg::HEADER_BYTES) : '0;
          r1.act      = fhle_pkg::ACT_COMMIT_ACK;
          r1.typ      = cfg.code_hs;
        end else begin
          n_res  = 2'd1;
          r0.act = fhle_pkg::ACT_COMMIT_ACK;
          r0.typ = cfg.code_hs;
        end
      end
      fhle_pkg::K_SEND_HS: begin
        n_res  = 2'd1;
        r0.typ = q_item.typ;
        if (tx_full_r) begin
          r0.act = fhle_pkg::ACT_BUSY;
        end else begin
          tx_full_nxt  = 1'b1;
          tx_comm_nxt  = 1'b0;
          tx_len_nxt   = q_item.len;
          tx_kind_nxt  = q_item.typ;
          tx_retry_nxt = cfg.max_retries;
          tx_dl_nxt    = tick_r + fhle_pkg::FIRST_GAP;
          r0.act       = fhle_pkg::ACT_DATA;
          r0.len       = q_item.len;
        end
      end
      fhle_pkg::K_SEND_UA: begin
        n_res  = 2'd1;
        r0.act = fhle_pkg::ACT_DATA;
        r0.typ = q_item.typ;
        r0.len = q_item.len;
      end
      fhle_pkg::K_SEND_BC: begin
        n_res  = 2'd1;
        r0.act = fhle_pkg::ACT_BROADCAST;
        r0.typ = q_item.typ;
        r0.len = q_item.len;
      end
      default: n_res = 2'd0;
    endcase
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  // update records on every transaction taken from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      tx_full_r  <= 1'b0;
      tx_comm_r  <= 1'b0;
      tx_len_r   <= '0;
      tx_kind_r  <= '0;
      tx_dl_r    <= '0;
      tx_retry_r <= '0;
      rx_full_r  <= 1'b0;
      rx_len_r   <= '0;
      rx_kind_r  <= '0;
    end else if (take) begin
      tick_r     <= tick_nxt;
      tx_full_r  <= tx_full_nxt;
      tx_comm_r  <= tx_comm_nxt;
      tx_len_r   <= tx_len_nxt;
      tx_kind_r  <= tx_kind_nxt;
      tx_dl_r    <= tx_dl_nxt;
      tx_retry_r <= tx_retry_nxt;
      rx_full_r  <= rx_full_nxt;
      rx_len_r   <= rx_len_nxt;
      rx_kind_r  <= rx_kind_nxt;
    end
  end

  // output register: the held second result goes first, then new work
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (pend_r && out_free) begin
      out_valid_r <= 1'b1;
      pend_r      <= 1'b0;
    end else if (take) begin
      out_valid_r <= (n_res != 2'd0);
      pend_r      <= (n_res == 2'd2);
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && out_free) begin
      out_r <= pend_res_r;
    end else if (take) begin
      out_r      <= r0;
      pend_res_r <= r1;
    end
  end

endmodule

// ----- sim/fhle_link_checker.sv -----
`timescale 1ns / 100ps

module fhle_link_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_opcode,
  input  logic [7:0]                  in_frame_header,
  input  logic [31:0]                 in_frame_network,
  input  logic [31:0]                 in_frame_destination,
  input  logic [7:0]                  in_frame_source,
  input  logic [fhle_pkg::LEN_W-1:0]  in_frame_length,
  input  logic                        in_move_response,
  input  logic [fhle_pkg::TYPE_W-1:0] in_send_type,
  input  logic [fhle_pkg::LEN_W-1:0]  in_send_length,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [fhle_pkg::ACT_W-1:0]  out_action,
  input  logic [fhle_pkg::TYPE_W-1:0] out_action_type,
  input  logic [fhle_pkg::LEN_W-1:0]  out_action_length,
  input  logic                        out_last_result,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [fhle_pkg::CFG_AW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  output int                          fail_count,
  output int                          pending_count,
  output int                          results_seen
);
  import fhle_pkg::*;

  // shadow configuration and link records
  cfg_t              link_cfg;
  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] tx_deadline;
  logic [7:0]        tx_retries_left;
  logic              tx_full;
  logic              tx_committing;
  logic [LEN_W-1:0]  tx_length;
  logic [TYPE_W-1:0] tx_kind;
  logic              rx_full;
  logic [LEN_W-1:0]  rx_length;
  logic [TYPE_W-1:0] rx_kind;

  result_t expected_actions[$];
  result_t batch[$];
  result_t want;
  int      fails;
  int      seen;

  task automatic note(input logic [ACT_W-1:0] act, input logic [TYPE_W-1:0] typ,
                      input logic [LEN_W-1:0] len);
    result_t r;
    r.act  = act;
    r.typ  = typ;
    r.len  = len;
    r.last = 1'b0;
    batch.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
      fails++;
    end
  endtask

  // work out the commands caused by one accepted input transaction
  task automatic predict_link(input logic [1:0] op, input logic [7:0] hdr,
                              input logic [31:0] net, input logic [31:0] dst,
                              input logic [7:0] src, input logic [LEN_W-1:0] len,
                              input logic mv, input logic [TYPE_W-1:0] st,
                              input logic [LEN_W-1:0] req_len);
    logic [TYPE_W-1:0] tt;
    logic [LEN_W-1:0]  sl;
    logic              accept;
    result_t           r;
    int                k;
    batch.delete();
    tt = hdr[TYPE_W-1:0];
    case (op)
      OP_FRAME: begin
        // filter on length, network, direction, device and parent
        accept = (len >= HEADER_BYTES) && (net == link_cfg.network_id);
        if (accept && tt != link_cfg.code_bc) begin
          if (!hdr[DIR_BIT] || dst != link_cfg.device_id)
            accept = 1'b0;
          else if (src[CID_W-1:0] != link_cfg.parent && len > MOVE_CHECK && !mv)
            accept = 1'b0;
        end
        if (accept) begin
          case (hdr[7:6])
            PT_ACK: begin
              if (tx_full) begin
                tx_retries_left = link_cfg.max_retries;
                if (tt != BUSY_CODE) begin
                  tx_committing = 1'b1;
                  tx_deadline   = tick_count + RETRY_GAP;
                  note(ACT_COMMIT, link_cfg.code_hs, '0);
                end else begin
                  // peer is busy: wait the longer gap
                  tx_deadline = tick_count + FIRST_GAP;
                  note(ACT_BUSY, tt, '0);
                end
              end
            end
            PT_CACK: begin
              tx_full = 1'b0;
              note(ACT_DONE, tx_kind, '0);
            end
            PT_DATA: begin
              if (tt == link_cfg.code_ua || tt == link_cfg.code_bc) begin
                note(ACT_DELIVER, tt, LEN_W'(len - HEADER_BYTES));
              end else if (tt == link_cfg.code_hs) begin
                // hold the first copy, acknowledge every copy
                if (!rx_full) begin
                  rx_length = len;
                  rx_kind   = tt;
                  rx_full   = 1'b1;
                end
                note(ACT_ACK, rx_kind, '0);
              end
            end
            default: begin
              if (rx_full) begin
                rx_full = 1'b0;
                note(ACT_DELIVER_BUF, rx_kind,
                     (rx_length >= HEADER_BYTES) ? LEN_W'(rx_length - HEADER_BYTES) : '0);
              end
              note(ACT_COMMIT_ACK, link_cfg.code_hs, '0);
            end
          endcase
        end
      end
      OP_TICK: begin
        tick_count = tick_count + 1'b1;
        if (tx_full && tx_deadline == tick_count) begin
          if (tx_retries_left == 0) begin
            tx_retries_left = 8'hff;
            tx_full         = 1'b0;
            note(ACT_ERROR, tx_kind, '0);
          end else begin
            tx_retries_left = tx_retries_left - 1'b1;
            tx_deadline     = tick_count + RETRY_GAP;
            if (tx_committing)
              note(ACT_COMMIT, link_cfg.code_hs, '0);
            else
              note(ACT_DATA, tx_kind, tx_length);
          end
        end
      end
      OP_SEND: begin
        sl = (req_len > MAX_SEND) ? LEN_W'(MAX_SEND) : req_len;
        if (st == link_cfg.code_hs) begin
          if (tx_full) begin
            note(ACT_BUSY, st, '0);
          end else begin
            tx_length       = sl;
            tx_committing   = 1'b0;
            tx_retries_left = link_cfg.max_retries;
            tx_deadline     = tick_count + FIRST_GAP;
            tx_kind         = st;
            tx_full         = 1'b1;
            note(ACT_DATA, st, sl);
          end
        end else if (st == link_cfg.code_ua) begin
          note(ACT_DATA, st, sl);
        end else if (st == link_cfg.code_bc) begin
          note(ACT_BROADCAST, st, sl);
        end
      end
      default: ;
    endcase
    // flag the final command of this transaction
    for (k = 0; k < batch.size(); k++) begin
      r      = batch[k];
      r.last = (k == batch.size() - 1);
      expected_actions.push_back(r);
    end
  endtask

  initial begin
    fails = 0;
    seen  = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      link_cfg.max_retries = 8'd3;
      link_cfg.network_id  = '0;
      link_cfg.device_id   = '0;
      link_cfg.parent      = '0;
      link_cfg.code_hs     = 4'd0;
      link_cfg.code_bc     = 4'd1;
      link_cfg.code_ua     = 4'd2;
      tick_count      = '0;
      tx_deadline     = '0;
      tx_retries_left = '0;
      tx_full         = 1'b0;
      tx_committing   = 1'b0;
      tx_length       = '0;
      tx_kind         = '0;
      rx_full         = 1'b0;
      rx_length       = '0;
      rx_kind         = '0;
      expected_actions.delete();
    end else begin
      // compare the result leaving the block with the oldest expectation
      if (out_valid && !out_stall) begin
        seen++;
        if (expected_actions.size() == 0) begin
          $error("unexpected result: action %0d type %0d length %0d last %0d",
                 out_action, out_action_type, out_action_length, out_last_result);
          fails++;
        end else begin
          want = expected_actions.pop_front();
          check_field("action", 8'(want.act), 8'(out_action));
          check_field("action_type", 8'(want.typ), 8'(out_action_type));
          check_field("action_length", 8'(want.len), 8'(out_action_length));
          check_field("last_result", 8'(want.last), 8'(out_last_result));
        end
      end
      // track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_RETRIES: link_cfg.max_retries = cfg_data[7:0];
          REG_NETWORK_ID:  link_cfg.network_id  = cfg_data;
          REG_DEVICE_ID:   link_cfg.device_id   = cfg_data;
          REG_PARENT:      link_cfg.parent      = cfg_data[CID_W-1:0];
          REG_CODE_HS:     link_cfg.code_hs     = cfg_data[TYPE_W-1:0];
          REG_CODE_BC:     link_cfg.code_bc     = cfg_data[TYPE_W-1:0];
          REG_CODE_UA:     link_cfg.code_ua     = cfg_data[TYPE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_link(in_opcode, in_frame_header, in_frame_network, in_frame_destination,
                     in_frame_source, in_frame_length, in_move_response, in_send_type,
                     in_send_length);
    end
    fail_count    <= fails;
    pending_count <= expected_actions.size();
    results_seen  <= seen;
  end

endmodule

// ----- sim/four_way_handshake_link_engine_tb.sv -----
`timescale 1ns / 100ps

module four_way_handshake_link_engine_tb;
  import fhle_pkg::*;

  localparam int DRAIN_PAUSE    = 12;
  localparam int PHASE_ITEMS    = 215;
  localparam int RANDOM_PHASES  = 6;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_opcode = OP_TICK;
  logic [7:0]        in_frame_header = '0;
  logic [31:0]       in_frame_network = '0;
  logic [31:0]       in_frame_destination = '0;
  logic [7:0]        in_frame_source = '0;
  logic [LEN_W-1:0]  in_frame_length = '0;
  logic              in_move_response = 1'b0;
  logic [TYPE_W-1:0] in_send_type = '0;
  logic [LEN_W-1:0]  in_send_length = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ACT_W-1:0]  out_action;
  logic [TYPE_W-1:0] out_action_type;
  logic [LEN_W-1:0]  out_action_length;
  logic              out_last_result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [31:0]       cfg_data = '0;

  int   fail_count;
  int   pending_count;
  int   results_seen;
  int   items_sent = 0;
  int   send_pct = 0;
  int   recv_pct = 0;
  int   errors;
  cfg_t link_cfg;

  four_way_handshake_link_engine dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_frame_header      (in_frame_header),
    .in_frame_network     (in_frame_network),
    .in_frame_destination (in_frame_destination),
    .in_frame_source      (in_frame_source),
    .in_frame_length      (in_frame_length),
    .in_move_response     (in_move_response),
    .in_send_type         (in_send_type),
    .in_send_length       (in_send_length),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_action           (out_action),
    .out_action_type      (out_action_type),
    .out_action_length    (out_action_length),
    .out_last_result      (out_last_result),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  fhle_link_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_frame_header      (in_frame_header),
    .in_frame_network     (in_frame_network),
    .in_frame_destination (in_frame_destination),
    .in_frame_source      (in_frame_source),
    .in_frame_length      (in_frame_length),
    .in_move_response     (in_move_response),
    .in_send_type         (in_send_type),
    .in_send_length       (in_send_length),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_action           (out_action),
    .out_action_type      (out_action_type),
    .out_action_length    (out_action_length),
    .out_last_result      (out_last_result),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .fail_count           (fail_count),
    .pending_count        (pending_count),
    .results_seen         (results_seen)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random back-pressure on the result channel
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_pct);
  end

  // hard stop if the block hangs
  initial begin
    #(3_000_000);
    $display("four_way_handshake_link_engine_tb NOT OK");
    $finish;
  end

  function automatic logic [7:0] header_of(input logic [1:0] ptype, input logic dir,
                                           input logic [TYPE_W-1:0] tt);
    return {ptype, dir, 1'b0, tt};
  endfunction

  // present one transaction, idle first at random, hold until accepted
  task automatic push_item(input logic [1:0] op, input logic [7:0] hdr,
                           input logic [31:0] net, input logic [31:0] dst,
                           input logic [7:0] src, input logic [LEN_W-1:0] len,
                           input logic mv, input logic [TYPE_W-1:0] st,
                           input logic [LEN_W-1:0] sl);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_opcode            <= op;
    in_frame_header      <= hdr;
    in_frame_network     <= net;
    in_frame_destination <= dst;
    in_frame_source      <= src;
    in_frame_length      <= len;
    in_move_response     <= mv;
    in_send_type         <= st;
    in_send_length       <= sl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic frame_to_us(input logic [7:0] hdr, input logic [LEN_W-1:0] len,
                             input logic [7:0] src, input logic mv);
    push_item(OP_FRAME, hdr, link_cfg.network_id, link_cfg.device_id, src, len, mv,
              TYPE_W'($urandom), LEN_W'($urandom));
  endtask

  task automatic send_req(input logic [TYPE_W-1:0] st, input logic [LEN_W-1:0] sl);
    push_item(OP_SEND, 8'($urandom), $urandom, $urandom, 8'($urandom), LEN_W'($urandom),
              1'($urandom), st, sl);
  endtask

  task automatic tick_in();
    push_item(OP_TICK, 8'($urandom), $urandom, $urandom, 8'($urandom), LEN_W'($urandom),
              1'($urandom), TYPE_W'($urandom), LEN_W'($urandom));
  endtask

  // drop valid, drain every expected result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // write all seven registers while the block is idle
  task automatic apply_settings(input cfg_t s);
    logic [CFG_AW-1:0] reg_idx[7];
    logic [31:0]       reg_val[7];
    reg_idx = '{REG_MAX_RETRIES, REG_NETWORK_ID, REG_DEVICE_ID, REG_PARENT,
                REG_CODE_HS, REG_CODE_BC, REG_CODE_UA};
    reg_val = '{{24'd0, s.max_retries}, s.network_id, s.device_id, {26'd0, s.parent},
                {28'd0, s.code_hs}, {28'd0, s.code_bc}, {28'd0, s.code_ua}};
    settle();
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx[i];
      cfg_data  <= reg_val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    link_cfg = s;
  endtask

  function automatic cfg_t setting_for(input int phase);
    cfg_t s;
    s.max_retries = 8'($urandom_range(0, 4));
    s.network_id  = $urandom;
    s.device_id   = $urandom;
    s.parent      = CID_W'($urandom);
    s.code_hs     = TYPE_W'($urandom);
    s.code_bc     = TYPE_W'($urandom);
    s.code_ua     = TYPE_W'($urandom);
    case (phase)
      0: begin
        s = '{8'd2, 32'hC0DE_1234, 32'h0BAD_F00D, 6'h15, 4'd3, 4'd1, 4'd2};
      end
      1: begin
        s = '{8'd0, 32'h0000_0000, 32'hFFFF_FFFF, 6'h3F, 4'd0, 4'd15, 4'd7};
      end
      2: begin
        s = '{8'd255, 32'hFFFF_FFFF, 32'h0000_0000, 6'h00, 4'd15, 4'd0, 4'd8};
      end
      3: begin
        // all three codes the same
        s.max_retries = 8'd1;
        s.code_hs = 4'd5;
        s.code_bc = 4'd5;
        s.code_ua = 4'd5;
      end
      4: begin
        // handshake code equals the busy code
        s.max_retries = 8'd3;
        s.code_hs = BUSY_CODE;
        s.code_bc = 4'd9;
        s.code_ua = BUSY_CODE;
      end
      6: begin
        s.code_hs = 4'd6;
        s.code_bc = 4'd6;
        s.code_ua = 4'd2;
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic [TYPE_W-1:0] pick_code();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return link_cfg.code_hs;
    if (pick < 5) return link_cfg.code_bc;
    if (pick < 7) return link_cfg.code_ua;
    if (pick < 8) return BUSY_CODE;
    return TYPE_W'($urandom);
  endfunction

  // mostly well-formed traffic for the current setting, some noise
  task automatic random_item();
    int                r;
    logic [1:0]        op;
    logic [7:0]        hdr;
    logic [31:0]       net;
    logic [31:0]       dst;
    logic [7:0]        src;
    logic [LEN_W-1:0]  len;
    logic              mv;
    logic [TYPE_W-1:0] st;
    logic [LEN_W-1:0]  sl;
    r   = $urandom_range(0, 99);
    op  = OP_FRAME;
    hdr = 8'($urandom);
    net = $urandom;
    dst = $urandom;
    src = 8'($urandom);
    len = LEN_W'($urandom);
    mv  = 1'($urandom);
    st  = TYPE_W'($urandom);
    sl  = LEN_W'($urandom);
    if (r < 30) begin
      op = OP_TICK;
    end else if (r < 50) begin
      op = OP_SEND;
      if ($urandom_range(0, 9) < 7) st = pick_code();
      if ($urandom_range(0, 9) < 8) sl = LEN_W'($urandom_range(0, MAX_SEND));
    end else if (r < 95) begin
      hdr[TYPE_W-1:0] = pick_code();
      hdr[DIR_BIT]    = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 9) != 0)
        len = LEN_W'($urandom_range(HEADER_BYTES, MAX_FRAME));
      if ($urandom_range(0, 19) != 0) net = link_cfg.network_id;
      if ($urandom_range(0, 19) != 0) dst = link_cfg.device_id;
      if ($urandom_range(0, 9) < 8) src[CID_W-1:0] = link_cfg.parent;
    end else begin
      op = 2'($urandom);
    end
    push_item(op, hdr, net, dst, src, len, mv, st, sl);
  endtask

  initial begin
    logic [7:0] our_src;
    logic [7:0] odd_src;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_pct = 9;
    recv_pct = 73;

    // directed pass: filters, every opcode and the handshake corners
    apply_settings(setting_for(0));
    our_src = {2'b11, link_cfg.parent};
    odd_src = {2'b00, ~link_cfg.parent};
    frame_to_us(header_of(PT_DATA, 1'b1, link_cfg.code_ua), 6'd9, our_src, 1'b0);
    push_item(OP_FRAME, header_of(PT_DATA, 1'b1, link_cfg.code_ua), ~link_cfg.network_id,
              link_cfg.device_id, our_src, 6'd30, 1'b0, 4'd0, 6'd0);
    frame_to_us(header_of(PT_DATA, 1'b0, link_cfg.code_ua), 6'd30, our_src, 1'b0);
    push_item(OP_FRAME, header_of(PT_DATA, 1'b1, link_cfg.code_ua), link_cfg.network_id,
              ~link_cfg.device_id, our_src, 6'd30, 1'b0, 4'd0, 6'd0);
    frame_to_us(header_of(PT_DATA, 1'b1, link_cfg.code_ua), 6'd21, odd_src, 1'b0);
    frame_to_us(header_of(PT_DATA, 1'b1, link_cfg.code_ua), 6'd20, odd_src, 1'b0);
    frame_to_us(header_of(PT_DATA, 1'b1, link_cfg.code_ua), 6'd63, odd_src, 1'b1);
    push_item(OP_FRAME, header_of(PT_DATA, 1'b0, link_cfg.code_bc), link_cfg.network_id,
              ~link_cfg.device_id, odd_src, 6'd40, 1'b0, 4'd0, 6'd0);
    frame_to_us(header_of(PT_ACK, 1'b1, link_cfg.code_hs), 6'd12, our_src, 1'b0);
    frame_to_us(header_of(PT_CACK, 1'b1, link_cfg.code_hs), 6'd12, our_src, 1'b0);
    send_req(link_cfg.code_hs, 6'd63);
    send_req(link_cfg.code_hs, 6'd5);
    send_req(link_cfg.code_ua, 6'd0);
    send_req(link_cfg.code_bc, 6'd53);
    send_req(4'hF, 6'd20);
    push_item(2'd3, 8'($urandom), $urandom, $urandom, 8'($urandom), LEN_W'($urandom),
              1'($urandom), TYPE_W'($urandom), LEN_W'($urandom));
    frame_to_us(header_of(PT_ACK, 1'b1, BUSY_CODE), 6'd10, our_src, 1'b0);
    repeat (3) tick_in();
    frame_to_us(header_of(PT_ACK, 1'b1, link_cfg.code_hs), 6'd10, our_src, 1'b0);
    frame_to_us(header_of(PT_CACK, 1'b1, link_cfg.code_hs), 6'd10, our_src, 1'b0);
    frame_to_us(header_of(PT_DATA, 1'b1, link_cfg.code_hs), 6'd63, our_src, 1'b0);
    frame_to_us(header_of(PT_DATA, 1'b1, link_cfg.code_hs), 6'd30, our_src, 1'b0);
    repeat (2)
      frame_to_us(header_of(PT_COMMIT, 1'b1, link_cfg.code_hs), 6'd15, our_src, 1'b0);

    // random traffic over several settings and idling patterns
    for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
      if (phase == 3) begin
        send_pct = 73;
        recv_pct = 9;
      end else if (phase == 5) begin
        send_pct = 0;
        recv_pct = 0;
      end
      apply_settings(setting_for(phase));
      repeat (PHASE_ITEMS) random_item();
    end

    settle();
    errors = fail_count + pending_count;
    $display("Covered %0d input transactions over seven register settings and three idling",
             items_sent);
    $display("patterns, with %0d results checked against the prediction.", results_seen);
    if (errors == 0) begin
      $display("four_way_handshake_link_engine_tb OK");
    end else begin
      $display("four_way_handshake_link_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
